// ===== design/mbc1_pkg.sv =====
// ----------------------------------------------------------------------------
// mbc1_pkg
// Shared widths, codes and defaults for the MBC1 bank mapper.
// ----------------------------------------------------------------------------
package mbc1_pkg;

    localparam int ADDR_W      = 16;
    localparam int DATA_W      = 8;
    localparam int TGT_W       = 2;
    localparam int ROM_ADDR_W  = 23;
    localparam int RAM_ADDR_W  = 15;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;
    localparam int ROM_CODE_W  = 4;
    localparam int RAM_CODE_W  = 3;
    localparam int BANK_W      = 7;

    localparam int ROM_ADDR_BITS_DEF = 23;
    localparam int RAM_ADDR_BITS_DEF = 15;

    // result kinds
    localparam logic [TGT_W-1:0] TGT_NONE    = 2'd0;
    localparam logic [TGT_W-1:0] TGT_ROM_RD  = 2'd1;
    localparam logic [TGT_W-1:0] TGT_RAM_RD  = 2'd2;
    localparam logic [TGT_W-1:0] TGT_RAM_WR  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROM_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAM_SIZE = 1'd1;

    // address[15:13] regions
    localparam logic [2:0] RGN_RAM_EN   = 3'b000;
    localparam logic [2:0] RGN_ROM_LOW  = 3'b001;
    localparam logic [2:0] RGN_BANK_HI  = 3'b010;
    localparam logic [2:0] RGN_MODE     = 3'b011;
    localparam logic [2:0] RGN_EXT_RAM  = 3'b101;

    localparam logic [3:0] RAM_EN_KEY   = 4'hA;

endpackage

// ===== design/mbc1_bank_mapper.sv =====
// ----------------------------------------------------------------------------
// mbc1_bank_mapper
// MBC1 cartridge bank controller: decodes CPU bus accesses and keeps banks.
// ----------------------------------------------------------------------------
// a request passes through the input register and then the result register
// throughput: one request per cycle while results are taken; the input register acts as a skid stage
// bank registers update as a request enters the result register, so the
// following request already sees them
// reset (synchronous, active low) clears valids and loads the power-on banks
module mbc1_bank_mapper #(
    parameter int ROM_ADDR_BITS = mbc1_pkg::ROM_ADDR_BITS_DEF,
    parameter int RAM_ADDR_BITS = mbc1_pkg::RAM_ADDR_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [mbc1_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mbc1_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // bus access requests
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic                               i_action,
    input  logic [mbc1_pkg::ADDR_W-1:0]        i_address,
    input  logic [mbc1_pkg::DATA_W-1:0]        i_data_in,
    // results
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [mbc1_pkg::TGT_W-1:0]         o_target,
    output logic [mbc1_pkg::ROM_ADDR_W-1:0]    o_rom_address,
    output logic [mbc1_pkg::RAM_ADDR_W-1:0]    o_ram_address,
    output logic [mbc1_pkg::DATA_W-1:0]        o_data_out
);
    import mbc1_pkg::*;

    localparam int RAM_EFF_BITS = (RAM_ADDR_BITS > RAM_ADDR_W) ? RAM_ADDR_W : RAM_ADDR_BITS;
    localparam logic [RAM_ADDR_W:0] RAM_MASK_W = (({{RAM_ADDR_W{1'b0}}, 1'b1}) << RAM_EFF_BITS)
                                                 - 1'b1;
    localparam logic [RAM_ADDR_W-1:0] RAM_MASK = RAM_MASK_W[RAM_ADDR_W-1:0];
    localparam int ROM_CAP = (ROM_ADDR_BITS > ROM_ADDR_W) ? ROM_ADDR_W : ROM_ADDR_BITS;

    // configuration
    logic [ROM_CODE_W-1:0] r_rom_size_code;
    logic [RAM_CODE_W-1:0] r_ram_size_code;

    // controller state
    logic [3:0]        r_ram_enable_nibble, n_ram_enable_nibble;
    logic [4:0]        r_rom_bank_low, n_rom_bank_low;
    logic [1:0]        r_bank_high, n_bank_high;
    logic              r_banking_mode, n_banking_mode;
    logic [BANK_W-1:0] r_lower_rom_bank, n_lower_rom_bank;
    logic [BANK_W-1:0] r_upper_rom_bank, n_upper_rom_bank;
    logic [1:0]        r_ram_bank, n_ram_bank;

    // input register
    logic              r_in_valid;
    logic              r_in_action;
    logic [ADDR_W-1:0] r_in_address;
    logic [DATA_W-1:0] r_in_data;

    // result register
    logic                  r_out_valid;
    logic [TGT_W-1:0]      r_target, n_target;
    logic [ROM_ADDR_W-1:0] r_rom_address, n_rom_address;
    logic [RAM_ADDR_W-1:0] r_ram_address, n_ram_address;
    logic [DATA_W-1:0]     r_data_out, n_data_out;

    logic       advance;
    logic [2:0] region;
    logic       ram_ok;
    logic [4:0] bank_sel;
    logic [4:0] bank_mask;
    logic [4:0] rom_bits;
    logic [ROM_ADDR_W:0] rom_mask_w;
    logic [BANK_W-1:0]   rom_bank;

    assign advance     = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready     = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    assign o_valid       = r_out_valid;
    assign o_target      = r_target;
    assign o_rom_address = r_rom_address;
    assign o_ram_address = r_ram_address;
    assign o_data_out    = r_data_out;

    assign region = r_in_address[ADDR_W-1:ADDR_W-3];
    assign ram_ok = (r_ram_enable_nibble == RAM_EN_KEY) && (r_ram_size_code != '0);

    // rom wrap mask: 32KB << code, codes above 8 act as 8, capped by ROM_ADDR_BITS and the port width
    always_comb begin
        if (r_rom_size_code > 4'd8) begin
            rom_bits = 5'(15 + 8);
        end else begin
            rom_bits = 5'd15 + {1'b0, r_rom_size_code};
        end
        if (rom_bits > 5'(ROM_CAP)) begin
            rom_bits = 5'(ROM_CAP);
        end
        rom_mask_w = ({{ROM_ADDR_W{1'b0}}, 1'b1} << rom_bits) - 1'b1;
    end

    // bank-low write mask by rom size
    always_comb begin
        case (r_rom_size_code)
            4'd0:    bank_mask = 5'h01;
            4'd1:    bank_mask = 5'h03;
            4'd2:    bank_mask = 5'h07;
            4'd3:    bank_mask = 5'h0F;
            default: bank_mask = 5'h1F;
        endcase
    end

    // bank zero select maps to bank one
    assign bank_sel = (r_in_data[4:0] == 5'd0) ? 5'd1 : r_in_data[4:0];
    assign rom_bank = r_in_address[14] ? r_upper_rom_bank : r_lower_rom_bank;

    always_comb begin
        n_ram_enable_nibble = r_ram_enable_nibble;
        n_rom_bank_low      = r_rom_bank_low;
        n_bank_high         = r_bank_high;
        n_banking_mode      = r_banking_mode;
        n_lower_rom_bank    = r_lower_rom_bank;
        n_upper_rom_bank    = r_upper_rom_bank;
        n_ram_bank          = r_ram_bank;
        n_target            = TGT_NONE;
        n_rom_address       = '0;
        n_ram_address       = '0;
        n_data_out          = '0;

        if (!r_in_action) begin
            if (!r_in_address[15]) begin
                n_target      = TGT_ROM_RD;
                n_rom_address = {{(ROM_ADDR_W-BANK_W-14){1'b0}}, rom_bank,
                                 r_in_address[13:0]} & rom_mask_w[ROM_ADDR_W-1:0];
            end else if (region == RGN_EXT_RAM && ram_ok) begin
                n_target      = TGT_RAM_RD;
                n_ram_address = {r_ram_bank, r_in_address[12:0]} & RAM_MASK;
            end
        end else if (region == RGN_RAM_EN) begin
            n_ram_enable_nibble = r_in_data[3:0];
        end else begin
            case (region)
                RGN_ROM_LOW: n_rom_bank_low = bank_sel & bank_mask;
                RGN_BANK_HI: n_bank_high    = r_in_data[1:0];
                RGN_MODE:    n_banking_mode = r_in_data[0];
                RGN_EXT_RAM: begin
                    if (ram_ok) begin
                        n_target      = TGT_RAM_WR;
                        n_ram_address = {r_ram_bank, r_in_address[12:0]} & RAM_MASK;
                        n_data_out    = r_in_data;
                    end
                end
                default: ;
            endcase
            // remap from the freshly written registers
            n_upper_rom_bank = {n_bank_high, n_rom_bank_low};
            if (n_banking_mode) begin
                n_lower_rom_bank = {n_bank_high, 5'd0};
                n_ram_bank       = (r_ram_size_code >= 3'd2) ? n_bank_high : 2'd0;
            end else begin
                n_lower_rom_bank = '0;
                n_ram_bank       = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_size_code     <= '0;
            r_ram_size_code     <= '0;
            r_ram_enable_nibble <= '0;
            r_rom_bank_low      <= 5'd1;
            r_bank_high         <= '0;
            r_banking_mode      <= 1'b0;
            r_lower_rom_bank    <= '0;
            r_upper_rom_bank    <= 7'd1;
            r_ram_bank          <= '0;
            r_in_valid          <= 1'b0;
            r_out_valid         <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_ROM_SIZE: r_rom_size_code <= i_cfg_data[ROM_CODE_W-1:0];
                    CFG_RAM_SIZE: r_ram_size_code <= i_cfg_data[RAM_CODE_W-1:0];
                    default: ;
                endcase
            end
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid         <= 1'b1;
                r_ram_enable_nibble <= n_ram_enable_nibble;
                r_rom_bank_low      <= n_rom_bank_low;
                r_bank_high         <= n_bank_high;
                r_banking_mode      <= n_banking_mode;
                r_lower_rom_bank    <= n_lower_rom_bank;
                r_upper_rom_bank    <= n_upper_rom_bank;
                r_ram_bank          <= n_ram_bank;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_action  <= i_action;
            r_in_address <= i_address;
            r_in_data    <= i_data_in;
        end
        if (advance) begin
            r_target      <= n_target;
            r_rom_address <= n_rom_address;
            r_ram_address <= n_ram_address;
            r_data_out    <= n_data_out;
        end
    end

    // upper bank always tracks the two bank registers
    a_upper_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_upper_rom_bank == {r_bank_high, r_rom_bank_low})
        else $error("upper rom bank out of step with bank registers");

    // mode 0 pins lower rom bank and ram bank to zero
    a_mode0_banks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_banking_mode |-> (r_lower_rom_bank == '0 && r_ram_bank == '0))
        else $error("mode 0 with nonzero secondary banks");

    // full skid stage with a stalled result must back-pressure
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_ready) |-> !o_ready)
        else $error("request taken with both stages full");

    // rom address field is cleared outside rom reads
    a_addr_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_target != TGT_ROM_RD) |-> (o_rom_address == '0))
        else $error("rom address set on non-rom result");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Bus-access checker for the MBC1 bank mapper. A directed table of accesses
// and size writes runs first. Random phases of access sequences follow, each
// under its own ROM and RAM size setting. A shadow copy of the bank registers
// predicts the results the table leaves open; all are checked in order.
// ----------------------------------------------------------------------------
module tb;
    import mbc1_pkg::*;

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    // bus map
    localparam logic [ADDR_W-1:0] CTRL_BANK_LO  = 16'h2000;
    localparam logic [ADDR_W-1:0] ROM_UPPER     = 16'h4000;
    localparam logic [ADDR_W-1:0] CTRL_MODE     = 16'h6000;
    localparam logic [ADDR_W-1:0] UNMAPPED_BASE = 16'h8000;
    localparam logic [ADDR_W-1:0] EXT_RAM_BASE  = 16'hA000;
    localparam logic [ADDR_W-1:0] EXT_RAM_END   = 16'hC000;
    localparam logic [31:0]       ROM_BANK_SIZE = 32'h4000;
    localparam logic [31:0]       RAM_BANK_SIZE = 32'h2000;

    localparam int MAX_REPORT     = 10;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int N_PHASES       = 8;
    localparam int PHASE_ITEMS    = 210;
    localparam int DRAIN_CYCLES   = 8;

    typedef struct packed {
        logic [TGT_W-1:0]      target;
        logic [ROM_ADDR_W-1:0] rom_addr;
        logic [RAM_ADDR_W-1:0] ram_addr;
        logic [DATA_W-1:0]     dout;
    } t_bus_result;

    typedef enum logic {ROW_ACCESS, ROW_CONFIG} t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic                  act;
        logic [ADDR_W-1:0]     addr;
        logic [DATA_W-1:0]     data;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic                  has_exp;
        t_bus_result           exp;
    } t_dir_row;

    localparam t_bus_result RES_NONE = '{TGT_NONE, 23'h0, 15'h0, 8'h00};
    localparam int N_DIR = 28;

    localparam t_dir_row DIR_ROWS [N_DIR] = '{
        // power-on banks, no RAM fitted
        '{ROW_ACCESS, ACT_READ,  16'h0000, 8'h00, CFG_ROM_SIZE, 1'b1,
          '{TGT_ROM_RD, 23'h0000, 15'h0, 8'h00}},
        '{ROW_ACCESS, ACT_READ,  16'h7FFF, 8'hFF, CFG_ROM_SIZE, 1'b1,
          '{TGT_ROM_RD, 23'h7FFF, 15'h0, 8'h00}},
        '{ROW_ACCESS, ACT_READ,  16'hA000, 8'h00, CFG_ROM_SIZE, 1'b1, RES_NONE},
        '{ROW_ACCESS, ACT_READ,  16'h8000, 8'h00, CFG_ROM_SIZE, 1'b1, RES_NONE},
        '{ROW_ACCESS, ACT_READ,  16'hFFFF, 8'hFF, CFG_ROM_SIZE, 1'b1, RES_NONE},
        '{ROW_ACCESS, ACT_WRITE, 16'h0000, 8'h0A, CFG_ROM_SIZE, 1'b1, RES_NONE},
        // enabled but absent RAM ignores the write
        '{ROW_ACCESS, ACT_WRITE, 16'hA123, 8'h55, CFG_ROM_SIZE, 1'b1, RES_NONE},
        '{ROW_CONFIG, ACT_READ,  16'h0000, 8'h08, CFG_ROM_SIZE, 1'b0, RES_NONE},
        '{ROW_CONFIG, ACT_READ,  16'h0000, 8'h04, CFG_RAM_SIZE, 1'b0, RES_NONE},
        '{ROW_ACCESS, ACT_WRITE, 16'hBFFF, 8'hFF, CFG_ROM_SIZE, 1'b1,
          '{TGT_RAM_WR, 23'h0, 15'h1FFF, 8'hFF}},
        '{ROW_ACCESS, ACT_READ,  16'hA000, 8'h00, CFG_ROM_SIZE, 1'b1,
          '{TGT_RAM_RD, 23'h0, 15'h0000, 8'h00}},
        // bank zero select turns into bank one
        '{ROW_ACCESS, ACT_WRITE, 16'h2000, 8'h00, CFG_ROM_SIZE, 1'b1, RES_NONE},
        '{ROW_ACCESS, ACT_READ,  16'h4000, 8'h00, CFG_ROM_SIZE, 1'b0, RES_NONE},
        '{ROW_ACCESS, ACT_WRITE, 16'h3FFF, 8'hFF, CFG_ROM_SIZE, 1'b1, RES_NONE},
        '{ROW_ACCESS, ACT_WRITE, 16'h5FFF, 8'hFF, CFG_ROM_SIZE, 1'b1, RES_NONE},
        '{ROW_ACCESS, ACT_READ,  16'h7FFF, 8'h00, CFG_ROM_SIZE, 1'b0, RES_NONE},
        '{ROW_ACCESS, ACT_WRITE, 16'h6000, 8'h01, CFG_ROM_SIZE, 1'b1, RES_NONE},
        '{ROW_ACCESS, ACT_READ,  16'h0000, 8'h00, CFG_ROM_SIZE, 1'b0, RES_NONE},
        '{ROW_ACCESS, ACT_READ,  16'hBFFF, 8'h00, CFG_ROM_SIZE, 1'b0, RES_NONE},
        '{ROW_ACCESS, ACT_WRITE, 16'h1FFF, 8'h00, CFG_ROM_SIZE, 1'b1, RES_NONE},
        '{ROW_ACCESS, ACT_READ,  16'hA000, 8'h00, CFG_ROM_SIZE, 1'b1, RES_NONE},
        // shrinking the ROM leaves banks alone, only the wrap changes
        '{ROW_CONFIG, ACT_READ,  16'h0000, 8'h00, CFG_ROM_SIZE, 1'b0, RES_NONE},
        '{ROW_ACCESS, ACT_READ,  16'h7FFF, 8'h00, CFG_ROM_SIZE, 1'b0, RES_NONE},
        '{ROW_ACCESS, ACT_WRITE, 16'h2000, 8'h20, CFG_ROM_SIZE, 1'b1, RES_NONE},
        '{ROW_ACCESS, ACT_WRITE, 16'h9000, 8'h12, CFG_ROM_SIZE, 1'b1, RES_NONE},
        '{ROW_ACCESS, ACT_READ,  16'h4000, 8'h00, CFG_ROM_SIZE, 1'b0, RES_NONE},
        '{ROW_ACCESS, ACT_WRITE, 16'h7FFF, 8'h00, CFG_ROM_SIZE, 1'b1, RES_NONE},
        '{ROW_ACCESS, ACT_READ,  16'h0000, 8'h00, CFG_ROM_SIZE, 1'b0, RES_NONE}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_ready;
    logic                  i_action;
    logic [ADDR_W-1:0]     i_address;
    logic [DATA_W-1:0]     i_data_in;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [TGT_W-1:0]      o_target;
    logic [ROM_ADDR_W-1:0] o_rom_address;
    logic [RAM_ADDR_W-1:0] o_ram_address;
    logic [DATA_W-1:0]     o_data_out;

    // shadow of the mapper registers
    logic [ROM_CODE_W-1:0] sh_rom_code = '0;
    logic [RAM_CODE_W-1:0] sh_ram_code = '0;
    logic [3:0]            sh_ram_en   = 4'h0;
    logic [4:0]            sh_bank_lo  = 5'd1;
    logic [1:0]            sh_bank_hi  = 2'd0;
    logic                  sh_mode     = 1'b0;
    logic [BANK_W-1:0]     sh_lo_bank  = 7'd0;
    logic [BANK_W-1:0]     sh_up_bank  = 7'd1;
    logic [1:0]            sh_ram_bank = 2'd0;

    t_bus_result result_q[$];
    int          err_cnt = 0;
    int          quiet_cycles = 0;
    bit          calm = 1'b0;

    mbc1_bank_mapper u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_action      (i_action),
        .i_address     (i_address),
        .i_data_in     (i_data_in),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_target      (o_target),
        .o_rom_address (o_rom_address),
        .o_ram_address (o_ram_address),
        .o_data_out    (o_data_out)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // decodes one bus access against the shadow registers and updates them
    function automatic t_bus_result decode_access(input logic act,
                                                  input logic [ADDR_W-1:0] addr,
                                                  input logic [DATA_W-1:0] din);
        t_bus_result res;
        logic [31:0] rom_lin;
        logic [31:0] rom_msk;
        logic [31:0] ram_lin;
        logic [31:0] ram_msk;
        logic [7:0]  sel;
        logic [4:0]  sel_msk;
        int          rom_bits;
        int          ram_bits;
        logic        ram_on;
        logic        in_ram;
        res = RES_NONE;
        rom_bits = 15 + ((sh_rom_code > 4'd8) ? 8 : int'(sh_rom_code));
        if (rom_bits > ROM_ADDR_BITS_DEF) begin
            rom_bits = ROM_ADDR_BITS_DEF;
        end
        rom_msk = (32'd1 << rom_bits) - 32'd1;
        ram_bits = (RAM_ADDR_BITS_DEF > 15) ? 15 : RAM_ADDR_BITS_DEF;
        ram_msk = (32'd1 << ram_bits) - 32'd1;
        ram_on = (sh_ram_en == RAM_EN_KEY) && (sh_ram_code != '0);
        in_ram = (addr >= EXT_RAM_BASE) && (addr < EXT_RAM_END);
        ram_lin = (32'(sh_ram_bank) * RAM_BANK_SIZE + 32'(addr - EXT_RAM_BASE)) & ram_msk;
        if (act == ACT_READ) begin
            if (addr < ROM_UPPER) begin
                res.target = TGT_ROM_RD;
                rom_lin = (32'(sh_lo_bank) * ROM_BANK_SIZE + 32'(addr)) & rom_msk;
                res.rom_addr = rom_lin[ROM_ADDR_W-1:0];
            end else if (addr < UNMAPPED_BASE) begin
                res.target = TGT_ROM_RD;
                rom_lin = (32'(sh_up_bank) * ROM_BANK_SIZE + 32'(addr - ROM_UPPER)) & rom_msk;
                res.rom_addr = rom_lin[ROM_ADDR_W-1:0];
            end else if (in_ram && ram_on) begin
                res.target = TGT_RAM_RD;
                res.ram_addr = ram_lin[RAM_ADDR_W-1:0];
            end
        end else if (addr < CTRL_BANK_LO) begin
            sh_ram_en = din[3:0];
        end else begin
            if (addr < ROM_UPPER) begin
                sel = din;
                if (sel[4:0] == 5'd0) begin
                    sel = sel + 8'd1;
                end
                // bank mask follows the ROM size, capped at five bits
                case (sh_rom_code)
                    4'd0: sel_msk = 5'h01;
                    4'd1: sel_msk = 5'h03;
                    4'd2: sel_msk = 5'h07;
                    4'd3: sel_msk = 5'h0F;
                    default: sel_msk = 5'h1F;
                endcase
                sh_bank_lo = sel[4:0] & sel_msk;
            end else if (addr < CTRL_MODE) begin
                sh_bank_hi = din[1:0];
            end else if (addr < UNMAPPED_BASE) begin
                sh_mode = din[0];
            end else if (in_ram && ram_on) begin
                res.target = TGT_RAM_WR;
                res.ram_addr = ram_lin[RAM_ADDR_W-1:0];
                res.dout = din;
            end
            // any write above the enable range remaps the banks
            sh_up_bank = {sh_bank_hi, sh_bank_lo};
            if (sh_mode) begin
                sh_lo_bank = {sh_bank_hi, 5'd0};
                sh_ram_bank = (sh_ram_code >= 3'd2) ? sh_bank_hi : 2'd0;
            end else begin
                sh_lo_bank = '0;
                sh_ram_bank = '0;
            end
        end
        return res;
    endfunction

    // size writes go out only once every pending result is back
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_valid <= 1'b0;
        while (result_q.size() != 0) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_ROM_SIZE) begin
            sh_rom_code = val[ROM_CODE_W-1:0];
        end else begin
            sh_ram_code = val[RAM_CODE_W-1:0];
        end
    endtask

    task automatic send_access(input logic act, input logic [ADDR_W-1:0] addr,
                               input logic [DATA_W-1:0] din, input logic has_exp,
                               input t_bus_result exp);
        t_bus_result pred;
        int unsigned gap;
        i_cfg_valid <= 1'b0;
        if (!calm && $urandom_range(99) < 10) begin
            gap = $urandom_range(1, 4);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_action  <= act;
        i_address <= addr;
        i_data_in <= din;
        do @(posedge i_clk); while (!o_ready);
        pred = decode_access(act, addr, din);
        result_q.push_back(has_exp ? exp : pred);
    endtask

    always @(posedge i_clk) begin
        t_bus_result got;
        t_bus_result want;
        i_ready <= calm || ($urandom_range(99) >= 10);
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                got = '{o_target, o_rom_address, o_ram_address, o_data_out};
                if (result_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORT) begin
                        $display("unexpected result: target %0d rom %h ram %h data %h",
                                 got.target, got.rom_addr, got.ram_addr, got.dout);
                    end
                end else begin
                    want = result_q.pop_front();
                    if (got != want) begin
                        err_cnt++;
                        if (err_cnt <= MAX_REPORT) begin
                            $display("mismatch: target %0d/%0d rom %h/%h ram %h/%h data %h/%h",
                                     want.target, got.target, want.rom_addr, got.rom_addr,
                                     want.ram_addr, got.ram_addr, want.dout, got.dout);
                        end
                    end
                end
            end
            if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        logic              act;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] din;
        logic [3:0]        rc;
        logic [2:0]        mc;
        int unsigned       pick;
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_ROM_SIZE;
        i_cfg_data  <= '0;
        i_valid     <= 1'b0;
        i_action    <= ACT_READ;
        i_address   <= '0;
        i_data_in   <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_DIR; r++) begin
            if (DIR_ROWS[r].kind == ROW_CONFIG) begin
                write_reg(DIR_ROWS[r].reg_idx, DIR_ROWS[r].data);
            end else begin
                send_access(DIR_ROWS[r].act, DIR_ROWS[r].addr, DIR_ROWS[r].data,
                            DIR_ROWS[r].has_exp, DIR_ROWS[r].exp);
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin rc = 4'd8;  mc = 3'd4; end
                1: begin rc = 4'd0;  mc = 3'd0; end
                2: begin rc = 4'd15; mc = 3'd7; end
                3: begin rc = 4'd3;  mc = 3'd1; end
                default: begin
                    rc = 4'($urandom_range(0, 11));
                    mc = 3'($urandom_range(0, 7));
                end
            endcase
            write_reg(CFG_ROM_SIZE, 8'(rc));
            write_reg(CFG_RAM_SIZE, 8'(mc));
            // one phase runs with both sides streaming flat out
            calm = (ph == 4);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(99);
                act  = ACT_WRITE;
                din  = 8'($urandom);
                if (pick < 35) begin
                    act  = ACT_READ;
                    addr = 16'($urandom_range(0, 16'h7FFF));
                end else if (pick < 55) begin
                    act  = 1'($urandom);
                    addr = EXT_RAM_BASE + 16'($urandom_range(0, 16'h1FFF));
                end else if (pick < 63) begin
                    // mostly the enable key, sometimes a disable
                    addr = 16'($urandom_range(0, 16'h1FFF));
                    if ($urandom_range(2) != 0) begin
                        din[3:0] = RAM_EN_KEY;
                    end
                end else if (pick < 73) begin
                    addr = CTRL_BANK_LO + 16'($urandom_range(0, 16'h1FFF));
                    if ($urandom_range(3) == 0) begin
                        din[4:0] = 5'd0;
                    end
                end else if (pick < 80) begin
                    addr = ROM_UPPER + 16'($urandom_range(0, 16'h1FFF));
                end else if (pick < 86) begin
                    addr = CTRL_MODE + 16'($urandom_range(0, 16'h1FFF));
                end else begin
                    act  = 1'($urandom);
                    addr = 16'($urandom);
                end
                send_access(act, addr, din, 1'b0, RES_NONE);
            end
        end
        calm = 1'b0;

        i_valid     <= 1'b0;
        i_cfg_valid <= 1'b0;
        while (result_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        err_cnt += result_q.size();
        if (err_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
